### rtl/totp_pkg.sv
// Package for the TOTP HMAC-SHA1 code generator.
// Holds SHA-1 constants, register indexes and shared types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package totp_pkg;
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_KEYLEN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_STEP = 3'd5;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    localparam logic [19:0] OTP_MOD = 20'd1000000;
    localparam logic [31:0] OTP_MASK = 32'h7FFFFFFF;
    // Reciprocal of the modulus scaled by 2^51; the quotient is exact for 31-bit operands.
    localparam logic [31:0] OTP_RECIP = 32'd2251799814;
    localparam int OTP_SHIFT = 51;

    typedef struct packed {
        logic start;
    } sha_ctl_t;

    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        if (rnd < 7'd20) return 32'h5A827999;
        else if (rnd < 7'd40) return 32'h6ED9EBA1;
        else if (rnd < 7'd60) return 32'h8F1BBCDC;
        else return 32'hCA62C1D6;
    endfunction
endpackage
`default_nettype wire

### rtl/totp_sha1_core.sv
// SHA-1 compression of one 512-bit block, one round per cycle.
// Uses totp_pkg; a 16-word shift window expands the schedule.
`timescale 1ns / 1ps
`default_nettype none
module totp_sha1_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire totp_pkg::sha_ctl_t  ctl_in,
    input  wire logic [511:0]        block_in,
    input  wire logic [159:0]        hash_in,
    output logic                     done_out,
    output logic [159:0]             hash_out
);
    import totp_pkg::*;

    logic [511:0] w_reg;
    logic [159:0] s_reg;
    logic [159:0] h_reg;
    logic [6:0]   rnd_reg;
    logic         run_reg;
    logic         done_reg;
    logic [31:0]  a, b, c, d, e, f, t, wn;

    always_comb begin
        a = s_reg[159:128]; b = s_reg[127:96]; c = s_reg[95:64];
        d = s_reg[63:32];   e = s_reg[31:0];
        if (rnd_reg < 7'd20) f = (b & c) | (~b & d);
        else if (rnd_reg < 7'd40 || rnd_reg >= 7'd60) f = b ^ c ^ d;
        else f = (b & c) | (b & d) | (c & d);
        t = {a[26:0], a[31:27]} + f + e + sha1_k(rnd_reg) + w_reg[511:480];
        wn = w_reg[511-13*32 -: 32] ^ w_reg[511-8*32 -: 32]
           ^ w_reg[511-2*32 -: 32] ^ w_reg[511:480];
        wn = {wn[30:0], wn[31]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl_in.start) begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
                w_reg <= block_in;
                s_reg <= hash_in;
                h_reg <= hash_in;
            end else if (run_reg) begin
                s_reg <= {t, a, {b[1:0], b[31:2]}, c, d};
                w_reg <= {w_reg[479:0], wn};
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == 7'd79) begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done_out = done_reg;
    assign hash_out = {h_reg[159:128] + s_reg[159:128], h_reg[127:96] + s_reg[127:96],
                       h_reg[95:64] + s_reg[95:64], h_reg[63:32] + s_reg[63:32],
                       h_reg[31:0] + s_reg[31:0]};
endmodule
`default_nettype wire

### rtl/totp_hmac_sha1_code.sv
// Top level of the TOTP HMAC-SHA1 six-digit code generator.
// Uses totp_pkg and totp_sha1_core.
//
// Usage: the s_ channel takes one beat per request; tuser is the kind
// (0 = timestamp, 1 = step count) and tdata holds the 31-bit value. The
// m_ channel returns one beat per request with the 20-bit code in tdata.
// The cfg_ channel writes the key words, key length and time step; it is
// always ready and should be used only while the block is idle.
// Operation: a timestamp is divided by a bit-serial divider, then four
// SHA-1 compressions of 80 rounds each run on one shared round unit,
// then truncation and a reciprocal multiplication followed by a
// subtraction for the modulo.
// s_tready is low from acceptance until the code beat is taken, so one
// request is in flight at a time. A stalled receiver holds the result in
// the output register. Reset restores key length 20, time step 30 and a
// zero key, and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module totp_hmac_sha1_code #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // [30:0] value, [31] zero fill
    input  wire logic        s_tuser,  // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // [19:0] code, [23:20] zero fill
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [totp_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [63:0] cfg_data
);
    import totp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_BLK, ST_WAIT, ST_TRUNC, ST_MOD, ST_OUT
    } state_t;

    state_t        state_reg;
    logic [255:0]  key_reg;
    logic [5:0]    keylen_reg;
    logic [30:0]   step_reg;
    logic [30:0]   quo_reg;
    logic [31:0]   rem_reg;
    logic [62:0]   prod_reg;
    logic [5:0]    cnt_reg;
    logic [1:0]    blk_reg;
    logic [159:0]  ih_reg;
    logic [159:0]  hash_reg;
    logic [19:0]   code_reg;
    logic          kind_reg;
    logic          start_reg;
    logic [511:0]  kblk, block;
    logic [159:0]  hin, hout;
    logic          sdone;
    logic [6:0]    cap;
    logic [31:0]   trial;
    logic [30:0]   div;
    logic [3:0]    off;
    sha_ctl_t      ctl;

    always_comb begin
        cap = (7'(keylen_reg) > 7'(MAX_KEY_BYTES)) ? 7'(MAX_KEY_BYTES) : 7'(keylen_reg);
        kblk = '0;
        for (int i = 0; i < 32; i++) begin
            if (i < int'(cap)) kblk[511-8*i -: 8] = key_reg[255-8*i -: 8];
        end
        unique case (blk_reg)
            2'd0: begin block = kblk ^ {64{8'h36}}; hin = SHA1_IV; end
            2'd1: begin
                block = {32'h0, 1'b0, quo_reg, 8'h80, 376'h0, 64'd576};
                hin = hash_reg;
            end
            2'd2: begin block = kblk ^ {64{8'h5C}}; hin = SHA1_IV; end
            default: begin
                block = {ih_reg, 8'h80, 280'h0, 64'd672};
                hin = hash_reg;
            end
        endcase
        div = (step_reg == '0) ? 31'd1 : step_reg;
        trial = {rem_reg[30:0], quo_reg[30]} - {1'b0, div};
        off = hash_reg[3:0];
    end

    assign ctl.start = start_reg;

    totp_sha1_core u_sha (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(ctl), .block_in(block),
        .hash_in(hin), .done_out(sdone), .hash_out(hout)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            key_reg <= '0;
            keylen_reg <= 6'd20;
            step_reg <= 31'd30;
            start_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_KEY0: key_reg[255:192] <= cfg_data;
                    REG_KEY1: key_reg[191:128] <= cfg_data;
                    REG_KEY2: key_reg[127:64] <= cfg_data;
                    REG_KEY3: key_reg[63:0] <= cfg_data;
                    REG_KEYLEN: keylen_reg <= cfg_data[5:0];
                    REG_STEP: step_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    quo_reg <= s_tdata[30:0];
                    kind_reg <= s_tuser;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= s_tuser ? ST_BLK : ST_DIV;
                    blk_reg <= 2'd0;
                end
                ST_DIV: begin
                    if (!trial[31]) rem_reg <= trial;
                    else rem_reg <= {rem_reg[30:0], quo_reg[30]};
                    quo_reg <= {quo_reg[29:0], ~trial[31]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd30) state_reg <= ST_BLK;
                end
                ST_BLK: begin
                    start_reg <= 1'b1;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: if (sdone) begin
                    hash_reg <= hout;
                    blk_reg <= blk_reg + 2'd1;
                    if (blk_reg == 2'd1) ih_reg <= hout;
                    state_reg <= (blk_reg == 2'd3) ? ST_TRUNC : ST_BLK;
                end
                ST_TRUNC: begin
                    rem_reg <= hash_reg[159-8*off -: 32] & OTP_MASK;
                    code_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= ST_MOD;
                end
                ST_MOD: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd0) begin
                        prod_reg <= {32'd0, rem_reg[30:0]} * {31'd0, OTP_RECIP};
                    end else begin
                        code_reg <= 20'(rem_reg - {20'd0, prod_reg[62:OTP_SHIFT]}
                                                  * {12'd0, OTP_MOD});
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: if (m_tready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {4'h0, code_reg};
    assign cfg_ready = 1'b1;

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> code_reg < OTP_MOD) else $error("code out of range");
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second request taken");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(code_reg))
        else $error("result lost under stall");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> !kind_reg) else $error("step count divided");
endmodule
`default_nettype wire

### tb/sv/totp_hmac_sha1_code_tb.sv
// Testbench for the TOTP HMAC-SHA1 six-digit code generator.
// Predicts each code with its own SHA-1 and HMAC model and checks every result beat.
// Depends on totp_pkg and totp_hmac_sha1_code.
`timescale 1ns / 1ps
module totp_hmac_sha1_code_tb;
    import totp_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // Shadow copy of the block's registers.
    logic [63:0] key_word [4];
    logic [5:0]  key_len;
    logic [30:0] step_secs;

    logic [19:0] code_queue[$];
    int          n_bad = 0;
    int          n_codes = 0;
    int          n_sent = 0;
    int          cycle_count = 0;
    int          hold_off = 0;
    bit          use_stall = 1'b1;

    totp_hmac_sha1_code i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] compress(input logic [159:0] hv, input logic [511:0] blk);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        {a, b, c, d, e} = hv;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d, hv[31:0] + e};
    endfunction

    function automatic logic [19:0] predict_code(input logic kind, input logic [30:0] value);
        logic [511:0] kblk, ipad, opad, blk;
        logic [159:0] inner_mac, mac;
        logic [31:0]  counter, word;
        int           cap, off;
        cap = (key_len > 32) ? 32 : key_len;
        kblk = '0;
        for (int i = 0; i < cap; i++) kblk[511 - 8 * i -: 8] = key_word[i / 8][63 - 8 * (i % 8) -: 8];
        ipad = kblk ^ {64{8'h36}};
        opad = kblk ^ {64{8'h5C}};
        counter = (kind == 1'b0) ? {1'b0, value} / ((step_secs == 0) ? 32'd1 : {1'b0, step_secs})
                                 : {1'b0, value};
        // Inner hash: 72 bytes, so two blocks.
        inner_mac = compress(SHA1_IV, ipad);
        blk = '0;
        blk[511 -: 64] = {32'd0, counter};
        blk[447 -: 8] = 8'h80;
        blk[63:0] = 64'd576;
        inner_mac = compress(inner_mac, blk);
        mac = compress(SHA1_IV, opad);
        blk = '0;
        blk[511 -: 160] = inner_mac;
        blk[351 -: 8] = 8'h80;
        blk[63:0] = 64'd672;
        mac = compress(mac, blk);
        off = mac[3:0];
        word = mac[159 - 8 * off -: 32] & 32'h7FFFFFFF;
        return 20'(word % 32'd1000000);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall pattern or always ready, or a long hold-off when requested.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= use_stall ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_codes <= n_codes + 1;
            if (code_queue.size() == 0) begin
                n_bad = n_bad + 1;
                if (n_bad <= 10) $display("Unexpected code beat %0d", m_tdata[19:0]);
            end else begin
                logic [19:0] want;
                want = code_queue.pop_front();
                if (m_tdata !== {4'd0, want}) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10)
                        $display("Code mismatch: expected %0d, got %0d", want, m_tdata);
                end
            end
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_word[idx[1:0]] = data;
            REG_KEYLEN: key_len = data[5:0];
            REG_STEP: step_secs = data[30:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_request(input logic kind, input logic [30:0] value);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, value};
        do @(posedge aclk); while (!s_tready);
        code_queue.push_back(predict_code(kind, value));
        n_sent++;
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (code_queue.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic load_key(input logic [5:0] len, input logic [30:0] secs);
        for (int i = 0; i < 4; i++) write_reg(CfgIdxW'(i), {$urandom, $urandom});
        write_reg(REG_KEYLEN, {58'd0, len});
        write_reg(REG_STEP, {33'd0, secs});
    endtask

    task automatic send_random(input int count);
        int burst;
        int gap;
        while (count > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && count > 0) begin
                send_request($urandom_range(0, 1), 31'($urandom));
                burst--; count--;
            end
            gap = $urandom_range(0, 3) * $urandom_range(0, 1) * 100;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic test_reset_defaults();
        // Reset values: zero key of length 20, 30-second step.
        send_request(1'b1, 31'd0);
        send_request(1'b1, 31'd1);
        send_request(1'b0, 31'd59);
        send_request(1'b0, 31'h7FFFFFFF);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        write_reg(REG_KEY0, 64'h3132333435363738);
        write_reg(REG_KEY1, 64'h3930313233343536);
        write_reg(REG_KEY2, 64'h3738393000000000);
        write_reg(REG_KEY3, 64'hFFFFFFFFFFFFFFFF);
        write_reg(REG_KEYLEN, 64'd20);
        write_reg(REG_STEP, 64'd30);
        send_request(1'b0, 31'd59);
        send_request(1'b0, 31'd1111111109);
        send_request(1'b0, 31'd2000000000);
        send_request(1'b1, 31'h7FFFFFFF);
        send_request(1'b1, 31'h55555555);
        send_request(1'b1, 31'h2AAAAAAA);
        wait_idle();
    endtask

    task automatic test_key_lengths();
        // Empty key, full 32-byte key, saturated lengths, and step extremes.
        load_key(6'd0, 31'd1);
        send_request(1'b0, 31'd12345);
        send_request(1'b1, 31'd12345);
        wait_idle();
        load_key(6'd32, 31'h7FFFFFFF);
        send_request(1'b0, 31'h7FFFFFFF);
        send_request(1'b0, 31'h7FFFFFFE);
        wait_idle();
        load_key(6'd33, 31'd0);
        send_request(1'b0, 31'd987654);
        wait_idle();
        load_key(6'd63, 31'd60);
        send_request(1'b0, 31'd3599);
        send_request(1'b1, 31'd7);
        wait_idle();
    endtask

    task automatic test_backpressure();
        // The receiver holds off while the sender keeps offering requests.
        hold_off = 3000;
        send_request(1'b1, 31'($urandom));
        send_request(1'b0, 31'($urandom));
        send_request(1'b1, 31'($urandom));
        wait_idle();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            load_key(6'($urandom_range(0, 63)), (phase == 0) ? 31'd1 : 31'($urandom_range(1, 90)));
            use_stall = (phase % 3 != 2);
            send_random(85);
            wait_idle();
        end
        use_stall = 1'b1;
    endtask

    initial begin
        key_word = '{default: 64'd0};
        key_len = 6'd20;
        step_secs = 31'd30;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_field_extremes();
        test_key_lengths();
        test_backpressure();
        test_random_settings();
        drop_valid();
        wait_idle();
        $display("Covered %0d requests over default, extreme and random keys and steps,", n_sent);
        $display("with %0d codes checked under back-pressure and bursty input.", n_codes);
        if (n_bad == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### totp_hmac_sha1_code.f
rtl/totp_pkg.sv
rtl/totp_sha1_core.sv
rtl/totp_hmac_sha1_code.sv
tb/sv/totp_hmac_sha1_code_tb.sv
